[hw/rtl/nts_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// nts_pkg
// Types, slot layout and decode functions of the number/time speech
// sequencer.
// ============================================================================
package nts_pkg;

    typedef enum logic [1:0] {
        CMD_TIME  = 2'd0,
        CMD_LAP   = 2'd1,
        CMD_DELTA = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        KIND_NUM         = 4'd0,
        KIND_HUNDRED_AND = 4'd1,
        KIND_AND         = 4'd2,
        KIND_POINT       = 4'd3,
        KIND_SILENCE     = 4'd4,
        KIND_BEST        = 4'd5,
        KIND_LAPTIME     = 4'd6,
        KIND_DOWN        = 4'd7,
        KIND_UP          = 4'd8
    } clip_kind_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [9:0] minutes;
        logic [5:0] seconds;
        logic [9:0] millis;
        logic       flag;
    } req_t;

    typedef struct packed {
        logic [3:0] clip_kind;
        logic [9:0] clip_value;
        logic       last;
    } clip_t;

    // Decimal digits of a value below one thousand.
    typedef struct packed {
        logic [3:0] h;
        logic [3:0] t;
        logic [3:0] u;
    } digit3_t;

    // Slot template of one run. A number takes five slots:
    // hundreds, and, tens, and, units/teens.
    localparam int NUM_SLOTS   = 24;
    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    localparam int NUMBER_SLOTS = 5;

    localparam logic [SLOT_W-1:0] SLOT_HEAD     = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_LAP_SIL  = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_MIN      = SLOT_W'(2);
    localparam logic [SLOT_W-1:0] SLOT_SZERO0   = SLOT_W'(7);
    localparam logic [SLOT_W-1:0] SLOT_SZERO1   = SLOT_W'(8);
    localparam logic [SLOT_W-1:0] SLOT_SEC      = SLOT_W'(9);
    localparam logic [SLOT_W-1:0] SLOT_POINT    = SLOT_W'(14);
    localparam logic [SLOT_W-1:0] SLOT_LEAD0    = SLOT_W'(15);
    localparam logic [SLOT_W-1:0] SLOT_LEAD1    = SLOT_W'(16);
    localparam logic [SLOT_W-1:0] SLOT_MS       = SLOT_W'(17);
    localparam logic [SLOT_W-1:0] SLOT_DELTA_SIL = SLOT_W'(22);
    localparam logic [SLOT_W-1:0] SLOT_DIR      = SLOT_W'(23);

    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    // One decoded request: which slots speak, plus the digits they need.
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        digit3_t              min_dig;
        digit3_t              sec_dig;
        digit3_t              ms_dig;
        logic                 flag;
    } plan_t;

    // Digit split by compare ladders; only meaningful for n <= 999.
    function automatic digit3_t split_digits(input logic [9:0] n);
        digit3_t    d;
        logic [9:0] rest;
        d.h = 4'd0;
        d.t = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (n >= 10'(k * 100))
                d.h = 4'(k);
        end
        rest = n - 10'(10'(d.h) * 10'd100);
        for (int k = 1; k <= 9; k++) begin
            if (rest >= 10'(k * 10))
                d.t = 4'(k);
        end
        d.u = 4'(rest - 10'(10'(d.t) * 10'd10));
        return d;
    endfunction

    function automatic logic [NUMBER_SLOTS-1:0] number_mask(input logic [9:0] n,
                                                           input digit3_t d);
        logic                    ok;
        logic                    rest_nz;
        logic                    low;
        logic [NUMBER_SLOTS-1:0] m;
        ok      = (n <= 10'd999);
        rest_nz = (d.t != 4'd0) || (d.u != 4'd0);
        low     = (d.h == 4'd0) || rest_nz;
        m[0] = ok && (d.h != 4'd0);
        m[1] = ok && (d.h >= 4'd2) && rest_nz;
        m[2] = ok && low && (d.t >= 4'd2);
        m[3] = m[2] && (d.u != 4'd0);
        m[4] = ok && low && ((d.t < 4'd2) || (d.u != 4'd0));
        return m;
    endfunction

    function automatic clip_t number_token(input logic [2:0] p, input digit3_t d);
        clip_t c;
        c.clip_kind  = KIND_NUM;
        c.clip_value = 10'd0;
        c.last       = 1'b0;
        case (p)
            3'd0:
            begin
                if (d.h == 4'd1 && d.t == 4'd0 && d.u == 4'd0)
                    c.clip_value = 10'd100;
                else if (d.h == 4'd1)
                    c.clip_kind = KIND_HUNDRED_AND;
                else
                    c.clip_value = 10'(10'(d.h) * 10'd100);
            end
            3'd1, 3'd3:
                c.clip_kind = KIND_AND;
            3'd2:
                c.clip_value = 10'(10'(d.t) * 10'd10);
            3'd4:
            begin
                if (d.t < 4'd2)
                    c.clip_value = 10'(10'(d.t) * 10'd10) + 10'(d.u);
                else
                    c.clip_value = 10'(d.u);
            end
            default:
                c.clip_kind = KIND_NUM;
        endcase
        return c;
    endfunction

    function automatic clip_t slot_token(input logic [SLOT_W-1:0] slot, input plan_t pl);
        clip_t c;
        c.clip_kind  = KIND_NUM;
        c.clip_value = 10'd0;
        c.last       = 1'b0;
        if (slot == SLOT_HEAD)
            c.clip_kind = pl.flag ? KIND_BEST : KIND_LAPTIME;
        else if (slot == SLOT_LAP_SIL || slot == SLOT_DELTA_SIL)
            c.clip_kind = KIND_SILENCE;
        else if (slot == SLOT_DIR)
            c.clip_kind = pl.flag ? KIND_DOWN : KIND_UP;
        else if (slot == SLOT_POINT)
            c.clip_kind = KIND_POINT;
        else if (slot >= SLOT_MIN && slot < SLOT_SZERO0)
            c = number_token(3'(slot - SLOT_MIN), pl.min_dig);
        else if (slot >= SLOT_SEC && slot < SLOT_POINT)
            c = number_token(3'(slot - SLOT_SEC), pl.sec_dig);
        else if (slot >= SLOT_MS && slot < SLOT_DELTA_SIL)
            c = number_token(3'(slot - SLOT_MS), pl.ms_dig);
        // zero-second and leading-zero slots keep the number-zero default
        return c;
    endfunction

endpackage

[hw/rtl/nts_front.sv]
`timescale 1ns / 1ps
// ============================================================================
// nts_front
// Request decoder: splits the time into digits and marks the slots that
// speak. Empty runs are taken and dropped here.
// ============================================================================
module nts_front (
    input  logic           req_valid,
    output logic           req_ready,
    input  nts_pkg::req_t  req,
    input  logic           q_full,
    output logic           q_push,
    output nts_pkg::plan_t q_plan
);
    import nts_pkg::*;

    logic    nonzero;
    logic    lap_on;
    logic    active;
    logic    sec_zero;
    digit3_t min_dig;
    digit3_t sec_dig;
    digit3_t ms_dig;
    logic [NUM_SLOTS-1:0] mask;

    assign min_dig = split_digits(req.minutes);
    assign sec_dig = split_digits(10'(req.seconds));
    assign ms_dig  = split_digits(req.millis);

    assign nonzero  = (req.minutes != 10'd0) || (req.seconds != 6'd0) || (req.millis != 10'd0);
    assign lap_on   = (req.cmd == CMD_LAP) && nonzero;
    assign active   = (req.cmd == CMD_TIME) || (req.cmd == CMD_DELTA) || lap_on;
    assign sec_zero = (req.seconds == 6'd0);

    always_comb
    begin
        mask = '0;
        mask[SLOT_HEAD]    = lap_on;
        mask[SLOT_LAP_SIL] = lap_on;
        if (active && req.minutes != 10'd0)
            mask[SLOT_MIN +: NUMBER_SLOTS] = number_mask(req.minutes, min_dig);
        mask[SLOT_SZERO0] = active && sec_zero;
        mask[SLOT_SZERO1] = active && sec_zero;
        if (active && !sec_zero)
            mask[SLOT_SEC +: NUMBER_SLOTS] = number_mask(10'(req.seconds), sec_dig);
        mask[SLOT_POINT] = active && !sec_zero;
        mask[SLOT_LEAD0] = active && (req.millis < 10'd100);
        mask[SLOT_LEAD1] = active && (req.millis < 10'd10);
        if (active)
            mask[SLOT_MS +: NUMBER_SLOTS] = number_mask(req.millis, ms_dig);
        mask[SLOT_DELTA_SIL] = (req.cmd == CMD_DELTA);
        mask[SLOT_DIR]       = (req.cmd == CMD_DELTA);
    end

    assign req_ready = !q_full;
    assign q_push    = req_valid && !q_full && (mask != '0);

    assign q_plan.mask    = mask;
    assign q_plan.min_dig = min_dig;
    assign q_plan.sec_dig = sec_dig;
    assign q_plan.ms_dig  = ms_dig;
    assign q_plan.flag    = req.flag;

endmodule

[hw/rtl/nts_queue.sv]
`timescale 1ns / 1ps
// ============================================================================
// nts_queue
// Short FIFO of decoded plans between the decoder and the clip sequencer.
// ============================================================================
module nts_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  nts_pkg::plan_t push_plan,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output nts_pkg::plan_t head
);
    import nts_pkg::*;

    plan_t                entry_reg [QDEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCOUNT_W-1:0]  count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == QCOUNT_W'(QDEPTH));
    assign valid   = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_plan;
    end

endmodule

[hw/rtl/nts_back.sv]
`timescale 1ns / 1ps
// ============================================================================
// nts_back
// Clip sequencer: walks the slot mask of the current plan, lowest slot
// first, one clip per cycle into the output register unless clip_ready stalls it.
// ============================================================================
module nts_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  nts_pkg::plan_t q_head,
    output logic           q_pop,
    output logic           clip_valid,
    input  logic           clip_ready,
    output nts_pkg::clip_t clip
);
    import nts_pkg::*;

    logic [NUM_SLOTS-1:0] mask_reg, mask_next;
    plan_t                plan_reg;
    logic                 out_valid_reg, out_valid_next;
    clip_t                out_reg, out_next;

    logic [NUM_SLOTS-1:0] rest;
    logic [SLOT_W-1:0]    slot;
    logic                 emit;
    logic                 run_done;

    // lowest pending slot
    always_comb
    begin
        slot = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                slot = SLOT_W'(i);
        end
    end

    assign rest     = mask_reg & (mask_reg - 1'b1);
    assign emit     = (mask_reg != '0) && (!out_valid_reg || clip_ready);
    assign run_done = (mask_reg == '0) || (emit && rest == '0);
    assign q_pop    = q_valid && run_done;

    always_comb
    begin
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (clip_ready)
            out_valid_next = 1'b0;
        if (emit)
        begin
            mask_next      = rest;
            out_valid_next = 1'b1;
            out_next       = slot_token(slot, plan_reg);
            out_next.last  = (rest == '0);
        end
        if (q_pop)
            mask_next = q_head.mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (q_pop)
            plan_reg <= q_head;
    end

    assign clip_valid = out_valid_reg;
    assign clip       = out_reg;

endmodule

[hw/rtl/number_time_speech_sequencer_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// number_time_speech_sequencer_unit
// Turns a time / lap / delta announcement request into a run of spoken
// clip tokens under Portuguese number rules.
// ============================================================================
//
//  channel | handshake              | payload        | role
//  --------+------------------------+----------------+-------------------------
//  req     | req_valid / req_ready  | nts_pkg::req_t | announcement request in
//  clip    | clip_valid / clip_ready| nts_pkg::clip_t| one clip token out
//
//  A request producing N clips (N up to 16) is played by the clip
//  sequencer with no gap between runs while the next plan is queued. The
//  first clip of a request passes the plan queue, the sequencer's mask and
//  plan registers and then the output register before it is shown. Rate
//  is set by the single-clip-per-cycle output register unless clip_ready
//  stalls it; the decoder takes a request every cycle while the two-entry
//  plan queue has room. Requests that speak nothing (an all-zero lap,
//  unused command) are taken and dropped by the decoder.
//  Reset clears the queue and the sequencer; a stalled clip holds its value.
//
// Structure:
//   nts_front : digit split and slot mask per request (combinational)
//   nts_queue : two-entry plan FIFO, decouples decode from playback
//   nts_back  : lowest-slot-first walker with the output register
// ============================================================================
module number_time_speech_sequencer_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  nts_pkg::req_t  req,
    output logic           clip_valid,
    input  logic           clip_ready,
    output nts_pkg::clip_t clip
);
    import nts_pkg::*;

    logic  q_full;
    logic  q_push;
    plan_t q_plan;
    logic  q_pop;
    logic  q_valid;
    plan_t q_head;

    // decode side
    nts_front u_front (
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_plan    (q_plan)
    );

    // decoupling queue
    nts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_plan (q_plan),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    // playback side
    nts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .clip_valid (clip_valid),
        .clip_ready (clip_ready),
        .clip       (clip)
    );

endmodule

[hw/rtl/nts_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// nts_checker
// Port-level checks of the speech sequencer, bound to the top level.
// ============================================================================
module nts_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input nts_pkg::req_t  req,
    input logic           clip_valid,
    input logic           clip_ready,
    input nts_pkg::clip_t clip
);
    import nts_pkg::*;

    // a stalled clip holds
    a_clip_hold: assert property (@(posedge clk) disable iff (!rst_n)
        clip_valid && !clip_ready |=> clip_valid && $stable(clip))
        else $error("clip changed while stalled");

    // only number clips carry a value
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        clip_valid && clip.clip_kind != KIND_NUM |-> clip.clip_value == 10'd0)
        else $error("non-number clip with nonzero value");

    // a lap heading is followed by a silence and never ends a run
    a_head_then_silence: assert property (@(posedge clk) disable iff (!rst_n)
        clip_valid && clip_ready &&
        (clip.clip_kind == KIND_BEST || clip.clip_kind == KIND_LAPTIME)
        |-> !clip.last ##1 (clip_valid && clip.clip_kind == KIND_SILENCE))
        else $error("lap heading not followed by silence");

    // faster/slower closes the run
    a_dir_last: assert property (@(posedge clk) disable iff (!rst_n)
        clip_valid && (clip.clip_kind == KIND_DOWN || clip.clip_kind == KIND_UP)
        |-> clip.last)
        else $error("direction clip not last");

endmodule

bind number_time_speech_sequencer_unit nts_checker u_nts_checker (.*);
